// ----- hw/rtl/ppc_pkg.sv -----
// polygon point containment: shared types, constants and operation codes
// no dependencies
`default_nettype none

package ppc_pkg;

  localparam int COORD_BITS     = 16;
  localparam int MAX_POINTS_DEF = 64;
  localparam int VCNT_BITS      = 7;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_BOUND = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_MEAN,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/ppc_if.sv -----
// polygon point containment: request and response channel interfaces
// depends on ppc_pkg
`default_nettype none

interface ppc_req_if;
  import ppc_pkg::*;
  logic   valid;
  logic   ready;
  op_e    operation;
  coord_t x;
  coord_t y;
  modport source (output valid, output operation, output x, output y, input ready);
  modport sink   (input valid, input operation, input x, input y, output ready);
endinterface

interface ppc_rsp_if;
  import ppc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 inside_res;
  coord_t               center_x;
  coord_t               center_y;
  logic [VCNT_BITS-1:0] vertex_count;
  logic                 status;
  modport source (output valid, output inside_res, output center_x, output center_y,
                  output vertex_count, output status, input ready);
  modport sink   (input valid, input inside_res, input center_x, input center_y,
                  input vertex_count, input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/ppc_ram.sv -----
// polygon point containment: generic ram, one write and one read port
// registered read data, no dependencies
`default_nettype none

module ppc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/polygon_point_containment.sv -----
// polygon point containment top level: vertex ram, walk pipeline, mean divider
// depends on ppc_pkg, ppc_if, ppc_ram
//
// usage:
//   req_i takes one request (operation, x, y); rsp_o returns exactly one response
//   per request with inside_res, center_x, center_y, vertex_count and status.
//   clear and add point go straight to the done state.
//   query point goes straight to the done state when the polygon is empty or
//   the point lies outside the bounding box, else it walks the n stored vertices:
//   the vertex ram is read once per vertex plus once more for the closing edge,
//   through a read stage, a multiply stage and an accumulate stage.
//   set bound walks the ram, then, if the polygon is not empty, runs a
//   one bit per cycle divider for the mean over SUM_W = COORD_BITS + count width
//   steps (23 steps at 64 vertices).
//   one request is in work at a time; req_i.ready is high only while idle.
//   the response sits in an output register; a new request is taken while it
//   waits, and a finished result holds in the done state until rsp_o is free.
//   reset empties the polygon, opens the box to the full range and zeroes the
//   mean; the vertex ram is not cleared, only written entries are ever read.
`default_nettype none

module polygon_point_containment #(
  parameter int MAX_POINTS = ppc_pkg::MAX_POINTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ppc_req_if.sink   req_i,
  ppc_rsp_if.source rsp_o
);

  import ppc_pkg::*;

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int IW  = $clog2(MAX_POINTS + 2);
  localparam int SW  = COORD_BITS + CW;
  localparam int DW  = COORD_BITS + 1;
  localparam int MW  = 2 * DW;
  localparam int WW  = CW + 3;
  localparam int DCW = $clog2(SW + 1);
  localparam int CB  = COORD_BITS;

  localparam coord_t CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CB-1){1'b0}}};

  state_e state_q, state_d;

  op_e            op_q;
  coord_t         px_q, py_q;
  logic [CW-1:0]  cnt_q;
  coord_t         bminx_q, bmaxx_q, bminy_q, bmaxy_q;
  coord_t         meanx_q, meany_q;
  logic [IW-1:0]  iss_q;
  logic           dvld_q, dfirst_q, evld_q;
  coord_t         ax_q, ay_q;
  logic [1:0]     q0_q;
  logic signed [MW-1:0] lhs_q, rhsn_q;
  logic           dypos_q;
  logic signed [2:0] diff_q;
  logic signed [WW-1:0] wind_q;
  coord_t         lox_q, hix_q, loy_q, hiy_q;
  logic signed [SW-1:0] sx_q, sy_q;
  logic           negx_q, negy_q;
  logic [SW-1:0]  qx_q, qy_q;
  logic [CW-1:0]  rx_q, ry_q;
  logic [DCW-1:0] dcnt_q;
  logic           inside_q, status_q;
  logic           rvld_q;

  logic           accept, issue, iss_done, drained, rsp_free;
  logic [IW-1:0]  total;
  logic [AW-1:0]  raddr;
  logic           we;
  logic [2*CB-1:0] rdata;
  coord_t         bx, by;
  logic [1:0]     q1;
  logic signed [2:0] diff_w;
  logic signed [DW-1:0] dx_w, dy_w, t_w, u_w;
  logic signed [MW:0] cmp_w;
  logic           left_w;
  logic signed [2:0] d_w;
  logic signed [WW-1:0] wind_d;
  logic           in_box;
  logic [CW:0]    shx, shy;
  logic           gex, gey;
  logic [SW-1:0]  mx_w, my_w;
  logic [CW+VCNT_BITS-1:0] cnt_ext;

  assign accept   = req_i.valid && req_i.ready;
  assign rsp_free = !rvld_q || rsp_o.ready;
  assign total    = IW'(cnt_q) + IW'(op_q == OP_QUERY);
  assign iss_done = (iss_q == total);
  assign issue    = (state_q == ST_WALK) && !iss_done;
  assign drained  = iss_done && !dvld_q && !evld_q;
  assign raddr    = (iss_q == IW'(cnt_q)) ? '0 : iss_q[AW-1:0];
  assign we       = accept && (req_i.operation == OP_ADD) && (cnt_q < CW'(MAX_POINTS));

  ppc_ram #(
    .WIDTH (2 * CB),
    .DEPTH (MAX_POINTS)
  ) u_vram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({req_i.x, req_i.y}),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign bx = rdata[2*CB-1:CB];
  assign by = rdata[CB-1:0];

  always_comb begin
    if (px_q >= bx) begin
      q1 = (py_q >= by) ? 2'd2 : 2'd1;
    end else begin
      q1 = (py_q >= by) ? 2'd3 : 2'd0;
    end
  end

  assign diff_w = $signed({1'b0, q1}) - $signed({1'b0, q0_q});
  assign dx_w   = DW'(ax_q) - DW'(bx);
  assign dy_w   = DW'(ay_q) - DW'(by);
  assign t_w    = DW'(by) - DW'(py_q);
  assign u_w    = DW'(px_q) - DW'(bx);

  assign cmp_w  = (MW+1)'(lhs_q) + (MW+1)'(rhsn_q);
  assign left_w = dypos_q ? (cmp_w < 0) : (cmp_w > 0);

  always_comb begin
    case (diff_q)
      -3'sd3:         d_w = 3'sd1;
      3'sd3:          d_w = -3'sd1;
      3'sd2, -3'sd2:  d_w = left_w ? -diff_q : diff_q;
      default:        d_w = diff_q;
    endcase
  end

  assign wind_d = wind_q + WW'(d_w);

  assign in_box = !(req_i.x < bminx_q || req_i.x > bmaxx_q ||
                    req_i.y < bminy_q || req_i.y > bmaxy_q);

  assign shx = {rx_q, qx_q[SW-1]};
  assign shy = {ry_q, qy_q[SW-1]};
  assign gex = shx >= (CW+1)'(cnt_q);
  assign gey = shy >= (CW+1)'(cnt_q);
  assign mx_w = negx_q ? (~qx_q + SW'(1)) : qx_q;
  assign my_w = negy_q ? (~qy_q + SW'(1)) : qy_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.operation == OP_BOUND) begin
            state_d = ST_WALK;
          end else if (req_i.operation == OP_QUERY && cnt_q != '0 && in_box) begin
            state_d = ST_WALK;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        if (drained) begin
          state_d = (op_q == OP_BOUND && cnt_q != '0) ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (dcnt_q == DCW'(SW - 1)) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN: state_d = ST_DONE;
      ST_DONE: begin
        if (rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bminx_q <= CMIN;
      bmaxx_q <= CMAX;
      bminy_q <= CMIN;
      bmaxy_q <= CMAX;
      meanx_q <= '0;
      meany_q <= '0;
      dvld_q  <= 1'b0;
      dfirst_q <= 1'b0;
      evld_q  <= 1'b0;
      rvld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      dvld_q   <= issue;
      dfirst_q <= issue && (iss_q == '0);
      evld_q   <= dvld_q && !dfirst_q && (op_q == OP_QUERY);

      if (accept) begin
        op_q     <= req_i.operation;
        px_q     <= req_i.x;
        py_q     <= req_i.y;
        status_q <= 1'b0;
        inside_q <= 1'b0;
        iss_q    <= '0;
        wind_q   <= '0;
        lox_q    <= CMAX;
        hix_q    <= CMIN;
        loy_q    <= CMAX;
        hiy_q    <= CMIN;
        sx_q     <= '0;
        sy_q     <= '0;
        case (req_i.operation)
          OP_CLEAR: begin
            cnt_q   <= '0;
            bminx_q <= CMIN;
            bmaxx_q <= CMAX;
            bminy_q <= CMIN;
            bmaxy_q <= CMAX;
          end
          OP_ADD: begin
            if (cnt_q < CW'(MAX_POINTS)) begin
              cnt_q <= cnt_q + CW'(1);
            end else begin
              status_q <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      if (issue) begin
        iss_q <= iss_q + IW'(1);
      end

      if (dvld_q) begin
        if (op_q == OP_QUERY) begin
          ax_q <= bx;
          ay_q <= by;
          q0_q <= q1;
          if (!dfirst_q) begin
            diff_q  <= diff_w;
            dypos_q <= dy_w > 0;
            lhs_q   <= u_w * dy_w;
            rhsn_q  <= dx_w * t_w;
          end
        end else begin
          if (bx < lox_q) lox_q <= bx;
          if (bx > hix_q) hix_q <= bx;
          if (by < loy_q) loy_q <= by;
          if (by > hiy_q) hiy_q <= by;
          sx_q <= sx_q + SW'(bx);
          sy_q <= sy_q + SW'(by);
        end
      end

      if (evld_q) begin
        wind_q <= wind_d;
      end

      if (state_q == ST_WALK && drained) begin
        if (op_q == OP_QUERY) begin
          inside_q <= (wind_q == WW'(4)) || (wind_q == -WW'(4));
        end else begin
          bminx_q <= lox_q;
          bmaxx_q <= hix_q;
          bminy_q <= loy_q;
          bmaxy_q <= hiy_q;
          negx_q  <= sx_q < 0;
          negy_q  <= sy_q < 0;
          qx_q    <= (sx_q < 0) ? SW'(-sx_q) : SW'(sx_q);
          qy_q    <= (sy_q < 0) ? SW'(-sy_q) : SW'(sy_q);
          rx_q    <= '0;
          ry_q    <= '0;
          dcnt_q  <= '0;
        end
      end

      if (state_q == ST_DIV) begin
        rx_q   <= gex ? CW'(shx - (CW+1)'(cnt_q)) : shx[CW-1:0];
        ry_q   <= gey ? CW'(shy - (CW+1)'(cnt_q)) : shy[CW-1:0];
        qx_q   <= {qx_q[SW-2:0], gex};
        qy_q   <= {qy_q[SW-2:0], gey};
        dcnt_q <= dcnt_q + DCW'(1);
      end

      if (state_q == ST_MEAN) begin
        meanx_q <= mx_w[CB-1:0];
        meany_q <= my_w[CB-1:0];
      end

      if (state_q == ST_DONE && rsp_free) begin
        rvld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rvld_q <= 1'b0;
      end
    end
  end

  assign cnt_ext = {{VCNT_BITS{1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && rsp_free) begin
      rsp_o.inside_res   <= inside_q;
      rsp_o.center_x     <= meanx_q;
      rsp_o.center_y     <= meany_q;
      rsp_o.vertex_count <= cnt_ext[VCNT_BITS-1:0];
      rsp_o.status       <= status_q;
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = rvld_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_polygon_point_containment.sv -----
// testbench for polygon_point_containment: drives operation requests, predicts
// each response with a behavioral winding-number model and compares them
// depends on ppc_pkg, ppc_if and the polygon_point_containment rtl
`timescale 1ns / 100ps

module tb_polygon_point_containment;
  import ppc_pkg::*;

  localparam int NPTS = 64;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct packed {
    op_e    op;
    coord_t x;
    coord_t y;
  } poly_req_t;

  typedef struct packed {
    logic                 hit;
    coord_t               cx;
    coord_t               cy;
    logic [VCNT_BITS-1:0] cnt;
    logic                 full;
  } poly_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ppc_req_if req_if ();
  ppc_rsp_if rsp_if ();

  polygon_point_containment #(.MAX_POINTS(NPTS)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow polygon state
  int          vx [NPTS];
  int          vy [NPTS];
  int          nvert;
  int          bminx, bmaxx, bminy, bmaxy;
  int          mx, my;

  poly_req_t   pending_reqs[$];
  poly_rsp_t   expected_rsps[$];
  int          errors = 0;
  bit          stim_done = 1'b0;
  bit          calm = 1'b0;
  longint      cycles = 0;

  function automatic int quad(int px, int py, int qx, int qy);
    if (px >= qx) return (py >= qy) ? 2 : 1;
    return (py >= qy) ? 3 : 0;
  endfunction

  function automatic bit winding_inside(int px, int py);
    int     ax, ay, bx, by, q0, q1, d, sum, j;
    longint lhs, rhs, dy;
    bit     left;
    if (nvert == 0) return 1'b0;
    if (px < bminx || px > bmaxx || py < bminy || py > bmaxy) return 1'b0;
    ax = vx[0]; ay = vy[0];
    q0 = quad(px, py, ax, ay);
    sum = 0;
    for (int i = 0; i < nvert; i++) begin
      j = (i + 1 == nvert) ? 0 : i + 1;
      bx = vx[j]; by = vy[j];
      q1 = quad(px, py, bx, by);
      d = q1 - q0;
      if (d == -3) d = 1;
      else if (d == 3) d = -1;
      else if (d == 2 || d == -2) begin
        dy = longint'(ay) - by;
        lhs = (longint'(px) - bx) * dy;
        rhs = -((longint'(ax) - bx) * (longint'(by) - py));
        left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
        if (left) d = -d;
      end
      sum += d;
      ax = bx; ay = by; q0 = q1;
    end
    return sum == 4 || sum == -4;
  endfunction

  function automatic poly_rsp_t predict_polygon(poly_req_t r);
    poly_rsp_t o;
    longint    sx, sy;
    o = '0;
    case (r.op)
      OP_CLEAR: begin
        nvert = 0;
        bminx = -32768; bmaxx = 32767; bminy = -32768; bmaxy = 32767;
      end
      OP_ADD: begin
        if (nvert < NPTS) begin
          vx[nvert] = r.x; vy[nvert] = r.y; nvert++;
        end else o.full = 1'b1;
      end
      OP_BOUND: begin
        bminx = 32767; bmaxx = -32768; bminy = 32767; bmaxy = -32768;
        sx = 0; sy = 0;
        for (int i = 0; i < nvert; i++) begin
          if (vx[i] < bminx) bminx = vx[i];
          if (vx[i] > bmaxx) bmaxx = vx[i];
          if (vy[i] < bminy) bminy = vy[i];
          if (vy[i] > bmaxy) bmaxy = vy[i];
          sx += vx[i]; sy += vy[i];
        end
        if (nvert != 0) begin
          mx = int'(sx / nvert); my = int'(sy / nvert);
        end
      end
      default: o.hit = winding_inside(r.x, r.y);
    endcase
    o.cx = coord_t'(mx);
    o.cy = coord_t'(my);
    o.cnt = VCNT_BITS'(nvert);
    return o;
  endfunction

  function automatic poly_req_t mk(op_e op, int x, int y);
    poly_req_t r;
    r.op = op; r.x = coord_t'(x); r.y = coord_t'(y);
    return r;
  endfunction

  function automatic int rcoord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535) - 32768;
      1: return ($urandom_range(0, 1) ? 32767 : -32768) - $urandom_range(0, 3) *
                ($urandom_range(0, 1) ? -1 : 1) * 0;
      default: return $urandom_range(0, 400) - 200;
    endcase
  endfunction

  // driver
  int req_idle = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.operation <= OP_CLEAR;
      req_if.x <= '0;
      req_if.y <= '0;
    end else begin
      if (req_if.valid && req_if.ready) void'(pending_reqs.pop_front());
      if (req_idle > 0) begin
        req_idle <= req_idle - 1;
        req_if.valid <= 1'b0;
      end else if (!(req_if.valid && !req_if.ready) && !calm && req_if.valid &&
                   $urandom_range(0, 15) == 0) begin
        req_idle <= $urandom_range(1, 15) - 1;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() > (req_if.valid && req_if.ready ? 1 : 0)) begin
        poly_req_t nx;
        nx = (req_if.valid && req_if.ready) ? pending_reqs[1] : pending_reqs[0];
        req_if.valid <= 1'b1;
        req_if.operation <= nx.op;
        req_if.x <= nx.x;
        req_if.y <= nx.y;
      end else req_if.valid <= 1'b0;
    end
  end

  // monitor and receiver stalls
  int rsp_idle = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      cycles <= cycles + 1;
      if (req_if.valid && req_if.ready)
        expected_rsps.push_back(predict_polygon(mk(req_if.operation, req_if.x, req_if.y)));
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected response");
          errors++;
        end else begin
          poly_rsp_t e;
          e = expected_rsps.pop_front();
          if (rsp_if.inside_res !== e.hit) begin
            $error("inside_res exp %0d got %0d", e.hit, rsp_if.inside_res);
            errors++;
          end
          if (rsp_if.center_x !== e.cx) begin
            $error("center_x exp %0d got %0d", e.cx, rsp_if.center_x);
            errors++;
          end
          if (rsp_if.center_y !== e.cy) begin
            $error("center_y exp %0d got %0d", e.cy, rsp_if.center_y);
            errors++;
          end
          if (rsp_if.vertex_count !== e.cnt) begin
            $error("vertex_count exp %0d got %0d", e.cnt, rsp_if.vertex_count);
            errors++;
          end
          if (rsp_if.status !== e.full) begin
            $error("status exp %0d got %0d", e.full, rsp_if.status);
            errors++;
          end
        end
      end
      if (rsp_idle > 0) begin
        rsp_idle <= rsp_idle - 1;
        rsp_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 12) == 0) begin
        rsp_idle <= $urandom_range(1, 15) - 1;
        rsp_if.ready <= 1'b0;
      end else rsp_if.ready <= 1'b1;
      if (cycles > CYCLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int n, cxr, cyr, rad;
    nvert = 0; mx = 0; my = 0;
    bminx = -32768; bmaxx = 32767; bminy = -32768; bmaxy = 32767;
    // directed
    pending_reqs.push_back(mk(OP_QUERY, 0, 0));
    pending_reqs.push_back(mk(OP_BOUND, 0, 0));
    pending_reqs.push_back(mk(OP_QUERY, 5, 5));
    pending_reqs.push_back(mk(OP_ADD, -32768, -32768));
    pending_reqs.push_back(mk(OP_ADD, 32767, -32768));
    pending_reqs.push_back(mk(OP_ADD, 32767, 32767));
    pending_reqs.push_back(mk(OP_ADD, -32768, 32767));
    pending_reqs.push_back(mk(OP_QUERY, 0, 0));
    pending_reqs.push_back(mk(OP_BOUND, 0, 0));
    pending_reqs.push_back(mk(OP_QUERY, 32767, 32767));
    pending_reqs.push_back(mk(OP_QUERY, -32768, 0));
    pending_reqs.push_back(mk(OP_QUERY, -1, -1));
    pending_reqs.push_back(mk(OP_CLEAR, -1, -1));
    pending_reqs.push_back(mk(OP_QUERY, 0, 0));
    for (int i = 0; i < NPTS + 2; i++)
      pending_reqs.push_back(mk(OP_ADD, (i % 2) ? -32768 : 32767, i * 500 - 16000));
    pending_reqs.push_back(mk(OP_BOUND, 0, 0));
    pending_reqs.push_back(mk(OP_QUERY, 100, 0));
    pending_reqs.push_back(mk(OP_CLEAR, 0, 0));
    // random polygons, mostly well formed
    while (pending_reqs.size() < 1150) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, NPTS + 3) : $urandom_range(1, 10);
      cxr = $urandom_range(0, 400) - 200; cyr = $urandom_range(0, 400) - 200;
      rad = $urandom_range(0, 1) ? $urandom_range(2, 60) : $urandom_range(1000, 30000);
      if ($urandom_range(0, 5) != 0) pending_reqs.push_back(mk(OP_CLEAR, rcoord(), rcoord()));
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0)
          pending_reqs.push_back(mk(OP_ADD, rcoord(), rcoord()));
        else
          pending_reqs.push_back(mk(OP_ADD,
            cxr + int'($urandom_range(0, 2 * rad)) - rad,
            cyr + int'($urandom_range(0, 2 * rad)) - rad));
      end
      if ($urandom_range(0, 5) != 0) pending_reqs.push_back(mk(OP_BOUND, rcoord(), rcoord()));
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 3) == 0)
          pending_reqs.push_back(mk(OP_QUERY, rcoord(), rcoord()));
        else
          pending_reqs.push_back(mk(OP_QUERY, cxr + int'($urandom_range(0, 2 * rad)) - rad,
                                    cyr + int'($urandom_range(0, 2 * rad)) - rad));
      end
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() < 150);
    calm = 1'b1;
    wait (pending_reqs.size() == 0);
    wait (expected_rsps.size() == 0);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
